/* src/jrss_pkg.sv */
package jrss_pkg;

  // Default widths of the segment counters.
  localparam int SEGMENT_INDEX_BITS_DEF = 16;
  localparam int SEGMENT_LENGTH_BITS_DEF = 24;

  // Result queue depth; a power of two so the pointers wrap naturally.
  localparam int QUEUE_DEPTH = 4;

  // Marker bytes.
  localparam logic [7:0] BYTE_FF = 8'hff;
  localparam logic [7:0] BYTE_00 = 8'h00;
  localparam logic [7:0] MARK_SOI = 8'hd8;
  localparam logic [7:0] MARK_SOS = 8'hda;
  localparam logic [7:0] MARK_EOI = 8'hd9;
  localparam logic [4:0] MARK_RST_HI = 5'b11010;

  typedef enum logic [2:0] {
    PH_SOI0,
    PH_SOI1,
    PH_HDR,
    PH_SKIP,
    PH_ENTROPY
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_SEG_END = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_SOI = 3'd1,
    ERR_PREFIX = 3'd2,
    ERR_LENGTH = 3'd3,
    ERR_TRUNC = 3'd4,
    ERR_EMPTY = 3'd5,
    ERR_MARKER = 3'd6,
    ERR_EOI = 3'd7
  } err_t;

  // Fixed-width part of one result.
  typedef struct packed {
    kind_t kind;
    logic [7:0] data;
    err_t err;
    logic last;
  } res_meta_t;

endpackage

/* src/jrss_parser.sv */
module jrss_parser
  import jrss_pkg::*;
#(
  parameter int SEGMENT_INDEX_BITS = SEGMENT_INDEX_BITS_DEF,
  parameter int SEGMENT_LENGTH_BITS = SEGMENT_LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  logic [7:0] data_byte,
  input  logic end_of_file,
  output logic [1:0] res_cnt,
  output res_meta_t res0,
  output res_meta_t res1,
  output logic [SEGMENT_INDEX_BITS-1:0] idx0,
  output logic [SEGMENT_INDEX_BITS-1:0] idx1,
  output logic [SEGMENT_LENGTH_BITS-1:0] len0
);

  localparam int IB = SEGMENT_INDEX_BITS;
  localparam int LB = SEGMENT_LENGTH_BITS;

  phase_t phase, phase_next;
  logic [1:0] header_position, header_position_next;
  logic [7:0] marker_code, marker_code_next;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic pending_ff, pending_ff_next;
  logic [IB-1:0] restart_count, restart_count_next;
  logic [LB-1:0] bytes_in_segment, bytes_in_segment_next;
  logic failed, failed_next;

  err_t err;
  logic accept;
  logic [1:0] n_bytes;
  logic seg_end;
  logic [1:0] add_cnt;
  logic [7:0] byte0;
  logic [15:0] hdr_len;
  logic [15:0] skip_dec;
  logic [LB:0] len_sum;
  logic [7:0] rst_marker;
  logic has_final;

  assign hdr_len = {skip_remaining[7:0], data_byte};
  assign skip_dec = skip_remaining - 16'd1;
  assign len_sum = {1'b0, bytes_in_segment} + (LB+1)'(add_cnt);
  assign rst_marker = {MARK_RST_HI, restart_count[2:0]};

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SOI0;
      header_position <= '0;
      marker_code <= '0;
      skip_remaining <= '0;
      pending_ff <= 1'b0;
      restart_count <= '0;
      bytes_in_segment <= '0;
      failed <= 1'b0;
    end else begin
      phase <= phase_next;
      header_position <= header_position_next;
      marker_code <= marker_code_next;
      skip_remaining <= skip_remaining_next;
      pending_ff <= pending_ff_next;
      restart_count <= restart_count_next;
      bytes_in_segment <= bytes_in_segment_next;
      failed <= failed_next;
    end
  end

  // Byte decode, state update and result assembly.
  always_comb begin
    phase_next = phase;
    header_position_next = header_position;
    marker_code_next = marker_code;
    skip_remaining_next = skip_remaining;
    pending_ff_next = pending_ff;
    restart_count_next = restart_count;
    bytes_in_segment_next = bytes_in_segment;
    failed_next = failed;
    err = ERR_NONE;
    accept = 1'b0;
    n_bytes = 2'd0;
    seg_end = 1'b0;
    add_cnt = 2'd0;
    byte0 = data_byte;

    if (fire && !failed) begin
      unique case (phase)
        PH_SOI0: begin
          if (data_byte != BYTE_FF) begin
            err = ERR_SOI;
          end else begin
            phase_next = PH_SOI1;
            if (end_of_file) err = ERR_TRUNC;
          end
        end
        PH_SOI1: begin
          if (data_byte != MARK_SOI) begin
            err = ERR_SOI;
          end else begin
            phase_next = PH_HDR;
            header_position_next = 2'd0;
            if (end_of_file) err = ERR_TRUNC;
          end
        end
        PH_HDR: begin
          case (header_position)
            2'd0: begin
              if (data_byte != BYTE_FF) begin
                err = ERR_PREFIX;
              end else begin
                header_position_next = 2'd1;
                if (end_of_file) err = ERR_TRUNC;
              end
            end
            2'd1: begin
              marker_code_next = data_byte;
              header_position_next = 2'd2;
              if (end_of_file) err = ERR_TRUNC;
            end
            2'd2: begin
              skip_remaining_next = {8'd0, data_byte};
              header_position_next = 2'd3;
              if (end_of_file) err = ERR_TRUNC;
            end
            default: begin
              if (hdr_len < 16'd2) begin
                err = ERR_LENGTH;
              end else begin
                skip_remaining_next = hdr_len - 16'd2;
                if (hdr_len == 16'd2) begin
                  // Empty body: the segment is skipped at once.
                  if (marker_code == MARK_SOS) begin
                    phase_next = PH_ENTROPY;
                    pending_ff_next = 1'b0;
                    bytes_in_segment_next = '0;
                    restart_count_next = '0;
                    if (end_of_file) err = ERR_EOI;
                  end else begin
                    phase_next = PH_HDR;
                    header_position_next = 2'd0;
                    if (end_of_file) err = ERR_TRUNC;
                  end
                end else begin
                  phase_next = PH_SKIP;
                  if (end_of_file) err = ERR_TRUNC;
                end
              end
            end
          endcase
        end
        PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) begin
            if (marker_code == MARK_SOS) begin
              phase_next = PH_ENTROPY;
              pending_ff_next = 1'b0;
              bytes_in_segment_next = '0;
              restart_count_next = '0;
              if (end_of_file) err = ERR_EOI;
            end else begin
              phase_next = PH_HDR;
              header_position_next = 2'd0;
              if (end_of_file) err = ERR_TRUNC;
            end
          end else if (end_of_file) begin
            err = ERR_TRUNC;
          end
        end
        PH_ENTROPY: begin
          if (!pending_ff) begin
            if (data_byte == BYTE_FF) begin
              pending_ff_next = 1'b1;
              if (end_of_file) err = ERR_EOI;
            end else if (end_of_file) begin
              err = ERR_EOI;
            end else begin
              n_bytes = 2'd1;
              add_cnt = 2'd1;
            end
          end else begin
            pending_ff_next = 1'b0;
            if (data_byte == BYTE_00) begin
              if (end_of_file) begin
                err = ERR_EOI;
              end else begin
                // Stuffed FF passes through as both bytes.
                n_bytes = 2'd2;
                add_cnt = 2'd2;
                byte0 = BYTE_FF;
              end
            end else if (data_byte == MARK_EOI) begin
              if (bytes_in_segment == '0) begin
                err = ERR_EMPTY;
              end else begin
                seg_end = 1'b1;
                if (end_of_file) accept = 1'b1;
                else err = ERR_EOI;
              end
            end else if (data_byte == rst_marker) begin
              if (bytes_in_segment == '0) begin
                err = ERR_EMPTY;
              end else begin
                seg_end = 1'b1;
                restart_count_next = restart_count + IB'(1);
                bytes_in_segment_next = '0;
                if (end_of_file) err = ERR_EOI;
              end
            end else begin
              err = ERR_MARKER;
            end
          end
          if (add_cnt != 2'd0) begin
            bytes_in_segment_next = len_sum[LB] ? '1 : len_sum[LB-1:0];
          end
        end
        default: err = ERR_SOI;
      endcase
    end

    // Result slots: data bytes or a segment end first, then the verdict.
    has_final = (err != ERR_NONE) || accept;
    res0 = '{kind: KIND_DATA, data: byte0, err: ERR_NONE, last: 1'b0};
    res1 = '{kind: KIND_DATA, data: BYTE_00, err: ERR_NONE, last: 1'b1};
    idx0 = restart_count;
    idx1 = restart_count_next;
    len0 = '0;
    res_cnt = 2'd0;
    if (n_bytes != 2'd0) begin
      res_cnt = n_bytes;
      res0.last = (n_bytes == 2'd1);
      idx1 = restart_count;
    end else if (seg_end) begin
      res0 = '{kind: KIND_SEG_END, data: 8'd0, err: ERR_NONE, last: !has_final};
      len0 = bytes_in_segment;
      res_cnt = has_final ? 2'd2 : 2'd1;
      if (err != ERR_NONE) begin
        res1 = '{kind: KIND_REJECT, data: 8'd0, err: err, last: 1'b1};
      end else begin
        res1 = '{kind: KIND_ACCEPT, data: 8'd0, err: ERR_NONE, last: 1'b1};
      end
    end else if (err != ERR_NONE) begin
      res0 = '{kind: KIND_REJECT, data: 8'd0, err: err, last: 1'b1};
      idx0 = restart_count_next;
      res_cnt = 2'd1;
    end

    // End of file re-arms the block; an error silences it until then.
    if (fire) begin
      if (end_of_file) begin
        phase_next = PH_SOI0;
        header_position_next = '0;
        marker_code_next = '0;
        skip_remaining_next = '0;
        pending_ff_next = 1'b0;
        restart_count_next = '0;
        bytes_in_segment_next = '0;
        failed_next = 1'b0;
      end else if (err != ERR_NONE) begin
        failed_next = 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // A rejected file stays silent until its final byte.
  assert property (@(posedge clk) disable iff (rst) (fire && failed) |-> (res_cnt == 2'd0))
    else $error("parser emitted results while failed");
  // The final byte of a file always returns the parser to its reset state.
  assert property (@(posedge clk) disable iff (rst)
    (fire && end_of_file) |=> (phase == PH_SOI0 && !failed && restart_count == '0))
    else $error("parser not re-armed after end of file");
`endif

endmodule

/* src/jrss_result_queue.sv */
module jrss_result_queue
  import jrss_pkg::*;
#(
  parameter int SEGMENT_INDEX_BITS = SEGMENT_INDEX_BITS_DEF,
  parameter int SEGMENT_LENGTH_BITS = SEGMENT_LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [1:0] push_cnt,
  input  res_meta_t res0,
  input  res_meta_t res1,
  input  logic [SEGMENT_INDEX_BITS-1:0] idx0,
  input  logic [SEGMENT_INDEX_BITS-1:0] idx1,
  input  logic [SEGMENT_LENGTH_BITS-1:0] len0,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] level,
  output logic out_valid,
  input  logic out_stall,
  output res_meta_t head,
  output logic [SEGMENT_INDEX_BITS-1:0] head_idx,
  output logic [SEGMENT_LENGTH_BITS-1:0] head_len
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

  res_meta_t meta_mem [QUEUE_DEPTH];
  logic [SEGMENT_INDEX_BITS-1:0] idx_mem [QUEUE_DEPTH];
  logic [SEGMENT_LENGTH_BITS-1:0] len_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_1;
  logic pop;

  assign wr_ptr_1 = wr_ptr + PTR_W'(1);
  assign out_valid = (level != '0);
  assign pop = out_valid && !out_stall;
  assign head = meta_mem[rd_ptr];
  assign head_idx = idx_mem[rd_ptr];
  assign head_len = len_mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_cnt);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      level <= level + LVL_W'(push_cnt) - LVL_W'(pop);
    end
  end

  // Storage; the second slot only ever carries a zero length.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      meta_mem[wr_ptr] <= res0;
      idx_mem[wr_ptr] <= idx0;
      len_mem[wr_ptr] <= len0;
    end
    if (push_cnt == 2'd2) begin
      meta_mem[wr_ptr_1] <= res1;
      idx_mem[wr_ptr_1] <= idx1;
      len_mem[wr_ptr_1] <= '0;
    end
  end

`ifndef SYNTHESIS
  // The queue never overflows.
  assert property (@(posedge clk) disable iff (rst) level <= LVL_W'(QUEUE_DEPTH))
    else $error("result queue overflow");
`endif

endmodule

/* src/jpeg_restart_segment_splitter_core.sv */
// JPEG restart segment splitter.
// Input channel: one raw file byte per transaction (data_byte, end_of_file),
// handshake in_valid / in_stall. Output channel: one result per transaction
// (kind, out_byte, segment_index, segment_length, error_code, last_of_run),
// handshake out_valid / out_stall.
// A byte produces zero, one or two results; last_of_run marks the final one.
// A byte is held in the input register and parsed from there; its results
// are registered in the result queue, whose head is offered on the output.
// Throughput: one byte per cycle while the receiver keeps up. A byte that
// causes two results (stuffed FF 00, or a segment end followed by a verdict)
// takes two output transactions, set by the single output port; the
// four-entry result queue absorbs this and the input register only waits
// when fewer than two queue slots are free.
// Reset clears the parser state, the input register and the queue, and the
// block then waits for the SOI of a new file.
// When the receiver stalls, results stay in the queue unchanged; with fewer than
// two slots free, in_stall rises; the pending byte waits in the input register.
module jpeg_restart_segment_splitter_core
  import jrss_pkg::*;
#(
  parameter int SEGMENT_INDEX_BITS = SEGMENT_INDEX_BITS_DEF,
  parameter int SEGMENT_LENGTH_BITS = SEGMENT_LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] data_byte,
  input  logic end_of_file,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic [SEGMENT_INDEX_BITS-1:0] segment_index,
  output logic [SEGMENT_LENGTH_BITS-1:0] segment_length,
  output logic [2:0] error_code,
  output logic last_of_run
);

  localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

  logic in_full;
  logic [7:0] byte_q;
  logic eof_q;
  logic fire;
  logic [LVL_W-1:0] level;
  logic [1:0] res_cnt;
  res_meta_t res0, res1, head;
  logic [SEGMENT_INDEX_BITS-1:0] idx0, idx1;
  logic [SEGMENT_LENGTH_BITS-1:0] len0;

  // A held byte is parsed once the queue has room for two results.
  assign fire = in_full && (level <= LVL_W'(QUEUE_DEPTH - 2));
  assign in_stall = in_full && !fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= data_byte;
      eof_q <= end_of_file;
    end
  end

  jrss_parser #(
    .SEGMENT_INDEX_BITS(SEGMENT_INDEX_BITS),
    .SEGMENT_LENGTH_BITS(SEGMENT_LENGTH_BITS)
  ) u_parser (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .data_byte(byte_q),
    .end_of_file(eof_q),
    .res_cnt(res_cnt),
    .res0(res0),
    .res1(res1),
    .idx0(idx0),
    .idx1(idx1),
    .len0(len0)
  );

  jrss_result_queue #(
    .SEGMENT_INDEX_BITS(SEGMENT_INDEX_BITS),
    .SEGMENT_LENGTH_BITS(SEGMENT_LENGTH_BITS)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_cnt(res_cnt),
    .res0(res0),
    .res1(res1),
    .idx0(idx0),
    .idx1(idx1),
    .len0(len0),
    .level(level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head(head),
    .head_idx(segment_index),
    .head_len(segment_length)
  );

  // Output fields.
  assign kind = head.kind;
  assign out_byte = head.data;
  assign error_code = head.err;
  assign last_of_run = head.last;

`ifndef SYNTHESIS
  // Both results of a byte are queued together, so a non-final one has a sibling.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_run) |-> (level >= LVL_W'(2)))
    else $error("result run split across queue writes");
`endif

endmodule

/* dv/tb_jpeg_restart_segment_splitter_core.sv */
`timescale 1ns / 1ps

module tb_jpeg_restart_segment_splitter_core;
  import jrss_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int BYTE_TARGET = 1050;
  localparam int QUIET_START = 400;
  localparam int QUIET_END = 900;
  localparam int IDLE_PERCENT = 9;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIRECTED_ROWS = 26;

  // One result of the splitter, as seen on the output port.
  typedef struct packed {
    kind_t kind;
    logic [7:0] data;
    logic [15:0] idx;
    logic [23:0] len;
    err_t err;
    logic last;
  } seg_result_t;

  // One byte of a file with its end-of-file flag.
  typedef struct packed {
    logic [7:0] b;
    logic eof;
  } file_byte_t;

  // A directed row either defers to the parser model or carries its own
  // single result (or none at all) for cases that are obvious by inspection.
  typedef struct packed {
    logic [7:0] b;
    logic eof;
    logic typed;
    logic silent;
    kind_t kind;
    err_t err;
  } directed_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = 8'h00;
  logic end_of_file = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [15:0] segment_index;
  logic [23:0] segment_length;
  logic [2:0] error_code;
  logic last_of_run;

  int cycle_count = 0;
  int mismatches = 0;
  int live_bytes = 0;

  file_byte_t byte_feed[$];
  seg_result_t file_results[$];
  seg_result_t byte_results[$];

  // Parser model state.
  phase_t ph;
  logic [1:0] hdr_pos;
  logic [7:0] mcode;
  logic [15:0] skip_left;
  logic ff_held;
  logic [15:0] rst_count;
  logic [23:0] seg_bytes;
  logic file_failed;

  directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    // Bad SOI, then bytes ignored until the end of the file.
    '{8'h00, 1'b0, 1'b1, 1'b0, KIND_REJECT, ERR_SOI},
    '{8'hff, 1'b0, 1'b1, 1'b1, KIND_DATA, ERR_NONE},
    '{8'hff, 1'b1, 1'b1, 1'b1, KIND_DATA, ERR_NONE},
    // File cut off inside SOI.
    '{8'hff, 1'b1, 1'b1, 1'b0, KIND_REJECT, ERR_TRUNC},
    // Good file: SOS with one payload byte, stuffing, a restart, EOI.
    '{8'hff, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'hd8, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'hff, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'hda, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'h03, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'h5a, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'hff, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'h7f, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'hff, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'hd0, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'h80, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'hff, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'hd9, 1'b1, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    // Header segment whose length field is below two.
    '{8'hff, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'hd8, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'hff, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'he0, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_DATA, ERR_NONE},
    '{8'h01, 1'b0, 1'b1, 1'b0, KIND_REJECT, ERR_LENGTH},
    '{8'h00, 1'b1, 1'b1, 1'b1, KIND_DATA, ERR_NONE}
  };

  jpeg_restart_segment_splitter_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .end_of_file(end_of_file),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .out_byte(out_byte),
    .segment_index(segment_index),
    .segment_length(segment_length),
    .error_code(error_code),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Random idling on either side, except for one quiet window.
  function automatic logic idle_now();
    if (cycle_count >= QUIET_START && cycle_count < QUIET_END) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PERCENT;
  endfunction

  function automatic void clear_parser();
    ph = PH_SOI0;
    hdr_pos = 2'd0;
    mcode = 8'h00;
    skip_left = 16'h0000;
    ff_held = 1'b0;
    rst_count = 16'h0000;
    seg_bytes = 24'h000000;
    file_failed = 1'b0;
  endfunction

  function automatic void emit(kind_t k, logic [7:0] d, logic [23:0] l, err_t e);
    seg_result_t r;
    r = '{k, d, rst_count, l, e, 1'b0};
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void count_bytes(int unsigned k);
    logic [24:0] sum;
    sum = {1'b0, seg_bytes} + 25'(k);
    seg_bytes = sum[24] ? 24'hffffff : sum[23:0];
  endfunction

  // A header segment has been skipped completely; SOS opens the entropy data.
  function automatic err_t header_done(logic eof);
    if (mcode == MARK_SOS) begin
      ph = PH_ENTROPY;
      ff_held = 1'b0;
      seg_bytes = 24'h000000;
      rst_count = 16'h0000;
      return eof ? ERR_EOI : ERR_NONE;
    end
    ph = PH_HDR;
    hdr_pos = 2'd0;
    return eof ? ERR_TRUNC : ERR_NONE;
  endfunction

  // Parses one file byte and leaves the results it causes in byte_results.
  task automatic parse_file_byte(input logic [7:0] b, input logic eof);
    err_t err;
    logic accept;
    logic [15:0] seg_len_field;
    seg_result_t tail;
    err = ERR_NONE;
    accept = 1'b0;
    byte_results.delete();
    if (file_failed) begin
      if (eof) clear_parser();
      return;
    end
    case (ph)
      PH_SOI0: begin
        if (b != BYTE_FF) err = ERR_SOI;
        else begin
          ph = PH_SOI1;
          if (eof) err = ERR_TRUNC;
        end
      end
      PH_SOI1: begin
        if (b != MARK_SOI) err = ERR_SOI;
        else begin
          ph = PH_HDR;
          hdr_pos = 2'd0;
          if (eof) err = ERR_TRUNC;
        end
      end
      PH_HDR: begin
        case (hdr_pos)
          2'd0: begin
            if (b != BYTE_FF) err = ERR_PREFIX;
            else begin
              hdr_pos = 2'd1;
              if (eof) err = ERR_TRUNC;
            end
          end
          2'd1: begin
            mcode = b;
            hdr_pos = 2'd2;
            if (eof) err = ERR_TRUNC;
          end
          2'd2: begin
            skip_left = {8'h00, b};
            hdr_pos = 2'd3;
            if (eof) err = ERR_TRUNC;
          end
          default: begin
            seg_len_field = {skip_left[7:0], b};
            if (seg_len_field < 16'd2) err = ERR_LENGTH;
            else begin
              skip_left = seg_len_field - 16'd2;
              if (skip_left == 16'h0000) err = header_done(eof);
              else begin
                ph = PH_SKIP;
                if (eof) err = ERR_TRUNC;
              end
            end
          end
        endcase
      end
      PH_SKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'h0000) err = header_done(eof);
        else if (eof) err = ERR_TRUNC;
      end
      PH_ENTROPY: begin
        if (!ff_held) begin
          if (b == BYTE_FF) begin
            ff_held = 1'b1;
            if (eof) err = ERR_EOI;
          end else if (eof) err = ERR_EOI;
          else begin
            emit(KIND_DATA, b, 24'h0, ERR_NONE);
            count_bytes(1);
          end
        end else begin
          ff_held = 1'b0;
          if (b == BYTE_00) begin
            if (eof) err = ERR_EOI;
            else begin
              emit(KIND_DATA, BYTE_FF, 24'h0, ERR_NONE);
              emit(KIND_DATA, BYTE_00, 24'h0, ERR_NONE);
              count_bytes(2);
            end
          end else if (b == MARK_EOI) begin
            if (seg_bytes == 24'h0) err = ERR_EMPTY;
            else begin
              emit(KIND_SEG_END, 8'h00, seg_bytes, ERR_NONE);
              if (eof) accept = 1'b1;
              else err = ERR_EOI;
            end
          end else if (b == {MARK_RST_HI, rst_count[2:0]}) begin
            if (seg_bytes == 24'h0) err = ERR_EMPTY;
            else begin
              emit(KIND_SEG_END, 8'h00, seg_bytes, ERR_NONE);
              rst_count = rst_count + 16'd1;
              seg_bytes = 24'h0;
              if (eof) err = ERR_EOI;
            end
          end else err = ERR_MARKER;
        end
      end
      default: err = ERR_SOI;
    endcase

    if (err != ERR_NONE) emit(KIND_REJECT, 8'h00, 24'h0, err);
    else if (accept) emit(KIND_ACCEPT, 8'h00, 24'h0, ERR_NONE);
    if (byte_results.size() > 0) begin
      tail = byte_results.pop_back();
      tail.last = 1'b1;
      byte_results.insert(byte_results.size(), tail);
    end
    if (eof) clear_parser();
    else if (err != ERR_NONE) file_failed = 1'b1;
  endtask

  // Queues one byte for the driver along with the results it should cause.
  task automatic queue_byte(input logic [7:0] b, input logic eof, input logic typed,
                            input logic silent, input kind_t k, input err_t e);
    seg_result_t r;
    file_byte_t fbyte;
    if (!file_failed) live_bytes++;
    parse_file_byte(b, eof);
    if (typed) begin
      if (!silent) begin
        r = '{k, 8'h00, 16'h0000, 24'h000000, e, 1'b1};
        file_results.insert(file_results.size(), r);
      end
    end else begin
      foreach (byte_results[i]) file_results.insert(file_results.size(), byte_results[i]);
    end
    fbyte = '{b, eof};
    byte_feed.insert(byte_feed.size(), fbyte);
  endtask

  // Builds one file: mostly well formed with random content, sometimes
  // damaged, truncated, padded after EOI, or plain noise.
  task automatic add_random_file();
    logic [7:0] fb[$];
    logic [7:0] code;
    logic [7:0] v;
    int mode;
    int damage;
    int nhdr;
    int plen;
    int nseg;
    int slen;
    int cut;
    int rst_end;
    rst_end = 0;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 6)) fb.insert(fb.size(), 8'($urandom));
    end else begin
      fb.insert(fb.size(), BYTE_FF);
      fb.insert(fb.size(), MARK_SOI);
      nhdr = $urandom_range(0, 2);
      for (int h = 0; h <= nhdr; h++) begin
        code = 8'($urandom);
        if (code == MARK_SOS) code = 8'hdb;
        if (h == nhdr) code = MARK_SOS;
        plen = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 700) : $urandom_range(0, 5);
        fb.insert(fb.size(), BYTE_FF);
        fb.insert(fb.size(), code);
        fb.insert(fb.size(), 8'((plen + 2) >> 8));
        fb.insert(fb.size(), 8'(plen + 2));
        repeat (plen) fb.insert(fb.size(), 8'($urandom));
      end
      nseg = $urandom_range(1, 11);
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) begin
          fb.insert(fb.size(), BYTE_FF);
          fb.insert(fb.size(), {MARK_RST_HI, 3'((s - 1) % 8)});
          if (rst_end == 0) rst_end = fb.size();
        end
        slen = ($urandom_range(0, 30) == 0) ? 0 : $urandom_range(1, 8);
        repeat (slen) begin
          v = 8'($urandom);
          if (v == BYTE_FF || $urandom_range(0, 9) == 0) begin
            fb.insert(fb.size(), BYTE_FF);
            fb.insert(fb.size(), BYTE_00);
          end else fb.insert(fb.size(), v);
        end
      end
      fb.insert(fb.size(), BYTE_FF);
      fb.insert(fb.size(), MARK_EOI);

      damage = $urandom_range(0, 99);
      if (damage < 8) begin
        fb[$urandom_range(0, fb.size() - 1)] = 8'($urandom);
      end else if (damage < 16) begin
        cut = $urandom_range(1, fb.size() - 1);
        while (fb.size() > cut) void'(fb.pop_back());
      end else if (damage < 20) begin
        repeat ($urandom_range(1, 3)) fb.insert(fb.size(), 8'($urandom));
      end else if (damage < 24 && rst_end != 0) begin
        // File ends right on a restart marker.
        while (fb.size() > rst_end) void'(fb.pop_back());
      end
    end
    foreach (fb[i]) queue_byte(fb[i], i == fb.size() - 1, 1'b0, 1'b0, KIND_DATA, ERR_NONE);
  endtask

  // Input side: a new transaction is offered once the previous one is taken.
  always @(posedge clk) begin
    file_byte_t nxt;
    if (rst) in_valid <= 1'b0;
    else if (!in_valid || !in_stall) begin
      if (byte_feed.size() != 0 && !idle_now()) begin
        nxt = byte_feed.pop_front();
        in_valid <= 1'b1;
        data_byte <= nxt.b;
        end_of_file <= nxt.eof;
      end else in_valid <= 1'b0;
    end
  end

  // Output side stalls at random.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= idle_now();
  end

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Each output transaction is matched against the oldest pending result.
  always @(posedge clk) begin
    seg_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (file_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d byte %0h err %0d",
                 $time, kind, out_byte, error_code);
        mismatches++;
      end else begin
        want = file_results.pop_front();
        compare_field("kind", 32'(want.kind), 32'(kind));
        compare_field("out_byte", 32'(want.data), 32'(out_byte));
        compare_field("segment_index", 32'(want.idx), 32'(segment_index));
        compare_field("segment_length", 32'(want.len), 32'(segment_length));
        compare_field("error_code", 32'(want.err), 32'(error_code));
        compare_field("last_of_run", 32'(want.last), 32'(last_of_run));
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    clear_parser();
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      queue_byte(directed_rows[i].b, directed_rows[i].eof, directed_rows[i].typed,
                 directed_rows[i].silent, directed_rows[i].kind, directed_rows[i].err);
    end
    while (live_bytes < BYTE_TARGET) add_random_file();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (byte_feed.size() != 0 || in_valid) @(posedge clk);
    while (file_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (file_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, file_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* jpeg_restart_segment_splitter_core.f */
src/jrss_pkg.sv
src/jrss_parser.sv
src/jrss_result_queue.sv
src/jpeg_restart_segment_splitter_core.sv
dv/tb_jpeg_restart_segment_splitter_core.sv
